FILE: rtl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg
// Shared constants, codes and control types of the bounded ordered list unit.
// ----------------------------------------------------------------------------
package bol_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_INSERT     = 3'd4,
      CMD_REMOVE     = 3'd5,
      CMD_CONTAINS   = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_OK      = 2'd0,
      RS_EMPTY   = 2'd1,
      RS_BAD_POS = 2'd2,
      RS_FULL    = 2'd3
   } status_code_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_UP,
      FSM_UP_WR,
      FSM_DN_FIRST,
      FSM_DN_GRAB,
      FSM_DN,
      FSM_DN_WR,
      FSM_SCAN,
      FSM_SCAN_CMP
   } fsm_state_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_COUNT,
      SEL_POS,
      SEL_LAST
   } ptr_sel_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_IDX_DEC,
      RD_IDX_INC
   } rd_sel_type;

   typedef enum logic {
      WR_RD_DATA,
      WR_VALUE
   } wr_sel_type;

   typedef struct packed {
      logic            load;
      ptr_sel_type     idx_sel;
      ptr_sel_type     stop_sel;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            wr_en;
      wr_sel_type      wr_sel;
      logic            idx_inc;
      logic            idx_dec;
      logic            grab;
      logic            cnt_inc;
      logic            cnt_dec;
      logic            finish;
      status_code_type status;
      logic            found;
      logic            ret_removed;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic pos_over;
      logic pos_ge;
      logic at_stop;
      logic match;
   } dp_sts_type;

endpackage

FILE: rtl/bounded_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit
// Ordered list of up to CAPACITY signed 32-bit values with end and indexed
// push, pop, insert, remove and search commands.
// ----------------------------------------------------------------------------
// Usage: drive req_cmd, req_item_value and req_position with start high; the
// word is taken at the clock edge where start is high and busy is low. Exactly
// one response word follows on the rsp_ ports, marked by rsp_strobe for one
// cycle; the receiver has no way to hold it off.
// Steps, from the accepting edge to the response:
//   refused commands and the unused code: answered with no further step
//   push/insert: m entries moved toward the back, then the value written
//   pop/remove:  the removed entry read and kept, then m entries moved toward
//                the front
//   contains:    entries read and compared from the front until one matches,
//                else until every stored entry has been compared
// Pop front and a missed search on a full list take longest; the walk entry by
// entry through the single-port-pair entry RAM (one read, then one write, per
// moved entry) sets this. busy stays high until the cycle that presents the
// response, so a new command may be accepted in the same cycle it is shown.
// Reset (synchronous, active high) empties the list and clears the strobe;
// stored values need no clearing since only positions below the count are read.
// ----------------------------------------------------------------------------
module bounded_ordered_list_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [bol_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [bol_pkg::DATA_W-1:0]    req_item_value,
   input  logic [bol_pkg::POS_W-1:0]            req_position,
   output logic                                 rsp_strobe,
   output logic [bol_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [bol_pkg::DATA_W-1:0]    rsp_removed_value,
   output logic                                 rsp_found,
   output logic [bol_pkg::ENTRY_W-1:0]          rsp_entry_count
);

   bol_pkg::dp_cmd_type dp_cmd;
   bol_pkg::dp_sts_type dp_sts;

   bol_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .sts     (dp_sts),
      .cmd     (dp_cmd)
   );

   bol_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_item_value    (req_item_value),
      .req_position      (req_position),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_found         (rsp_found),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

FILE: rtl/bol_ram.sv
// ----------------------------------------------------------------------------
// bol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bol_ctrl.sv
// ----------------------------------------------------------------------------
// bol_ctrl
// Command sequencer: checks each command, then steps the datapath through
// gap opening, gap closing or the search walk.
// ----------------------------------------------------------------------------
module bol_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bol_pkg::CMD_W-1:0]    req_cmd,
   output logic                         busy,
   input  bol_pkg::dp_sts_type          sts,
   output bol_pkg::dp_cmd_type          cmd
);

   bol_pkg::fsm_state_type state_ff;
   bol_pkg::fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bol_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.idx_sel     = bol_pkg::SEL_ZERO;
      cmd.stop_sel    = bol_pkg::SEL_ZERO;
      cmd.rd_sel      = bol_pkg::RD_IDX;
      cmd.wr_sel      = bol_pkg::WR_RD_DATA;
      cmd.status      = bol_pkg::RS_OK;
      unique case (state_ff)
         bol_pkg::FSM_IDLE: begin
            if (start) begin
               unique case (bol_pkg::cmd_type'(req_cmd))
                  bol_pkg::CMD_PUSH_BACK, bol_pkg::CMD_PUSH_FRONT: begin
                     if (sts.full) begin
                        cmd.finish = 1'b1;
                        cmd.status = bol_pkg::RS_FULL;
                     end else begin
                        cmd.load     = 1'b1;
                        cmd.idx_sel  = bol_pkg::SEL_COUNT;
                        cmd.stop_sel = (bol_pkg::cmd_type'(req_cmd) == bol_pkg::CMD_PUSH_BACK)
                                       ? bol_pkg::SEL_COUNT : bol_pkg::SEL_ZERO;
                        state_in     = bol_pkg::FSM_UP;
                     end
                  end
                  bol_pkg::CMD_POP_BACK, bol_pkg::CMD_POP_FRONT: begin
                     if (sts.empty) begin
                        cmd.finish = 1'b1;
                        cmd.status = bol_pkg::RS_EMPTY;
                     end else begin
                        cmd.load     = 1'b1;
                        cmd.idx_sel  = (bol_pkg::cmd_type'(req_cmd) == bol_pkg::CMD_POP_BACK)
                                       ? bol_pkg::SEL_LAST : bol_pkg::SEL_ZERO;
                        cmd.stop_sel = bol_pkg::SEL_LAST;
                        state_in     = bol_pkg::FSM_DN_FIRST;
                     end
                  end
                  bol_pkg::CMD_INSERT: begin
                     priority if (sts.empty) begin
                        cmd.finish = 1'b1;
                        cmd.status = bol_pkg::RS_EMPTY;
                     end else if (sts.pos_over) begin
                        cmd.finish = 1'b1;
                        cmd.status = bol_pkg::RS_BAD_POS;
                     end else if (sts.full) begin
                        cmd.finish = 1'b1;
                        cmd.status = bol_pkg::RS_FULL;
                     end else begin
                        cmd.load     = 1'b1;
                        cmd.idx_sel  = bol_pkg::SEL_COUNT;
                        cmd.stop_sel = bol_pkg::SEL_POS;
                        state_in     = bol_pkg::FSM_UP;
                     end
                  end
                  bol_pkg::CMD_REMOVE: begin
                     priority if (sts.empty) begin
                        cmd.finish = 1'b1;
                        cmd.status = bol_pkg::RS_EMPTY;
                     end else if (sts.pos_ge) begin
                        cmd.finish = 1'b1;
                        cmd.status = bol_pkg::RS_BAD_POS;
                     end else begin
                        cmd.load     = 1'b1;
                        cmd.idx_sel  = bol_pkg::SEL_POS;
                        cmd.stop_sel = bol_pkg::SEL_LAST;
                        state_in     = bol_pkg::FSM_DN_FIRST;
                     end
                  end
                  bol_pkg::CMD_CONTAINS: begin
                     cmd.load     = 1'b1;
                     cmd.idx_sel  = bol_pkg::SEL_ZERO;
                     cmd.stop_sel = bol_pkg::SEL_COUNT;
                     state_in     = bol_pkg::FSM_SCAN;
                  end
                  default: begin
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
         bol_pkg::FSM_UP: begin
            if (sts.at_stop) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = bol_pkg::WR_VALUE;
               cmd.cnt_inc = 1'b1;
               cmd.finish  = 1'b1;
               state_in    = bol_pkg::FSM_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bol_pkg::RD_IDX_DEC;
               state_in   = bol_pkg::FSM_UP_WR;
            end
         end
         bol_pkg::FSM_UP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_dec = 1'b1;
            state_in    = bol_pkg::FSM_UP;
         end
         bol_pkg::FSM_DN_FIRST: begin
            cmd.rd_en = 1'b1;
            state_in  = bol_pkg::FSM_DN_GRAB;
         end
         bol_pkg::FSM_DN_GRAB: begin
            cmd.grab = 1'b1;
            state_in = bol_pkg::FSM_DN;
         end
         bol_pkg::FSM_DN: begin
            if (sts.at_stop) begin
               cmd.cnt_dec     = 1'b1;
               cmd.finish      = 1'b1;
               cmd.ret_removed = 1'b1;
               state_in        = bol_pkg::FSM_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bol_pkg::RD_IDX_INC;
               state_in   = bol_pkg::FSM_DN_WR;
            end
         end
         bol_pkg::FSM_DN_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = bol_pkg::FSM_DN;
         end
         bol_pkg::FSM_SCAN: begin
            if (sts.at_stop) begin
               cmd.finish = 1'b1;
               state_in   = bol_pkg::FSM_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = bol_pkg::FSM_SCAN_CMP;
            end
         end
         bol_pkg::FSM_SCAN_CMP: begin
            if (sts.match) begin
               cmd.finish = 1'b1;
               cmd.found  = 1'b1;
               state_in   = bol_pkg::FSM_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = bol_pkg::FSM_SCAN;
            end
         end
         default: begin
            state_in = bol_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != bol_pkg::FSM_IDLE);

endmodule

FILE: rtl/bol_dpath.sv
// ----------------------------------------------------------------------------
// bol_dpath
// Entry store, count, walk pointer and response registers of the list.
// ----------------------------------------------------------------------------
module bol_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [bol_pkg::DATA_W-1:0]    req_item_value,
   input  logic [bol_pkg::POS_W-1:0]            req_position,
   input  bol_pkg::dp_cmd_type                  cmd,
   output bol_pkg::dp_sts_type                  sts,
   output logic                                 rsp_strobe,
   output logic [bol_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [bol_pkg::DATA_W-1:0]    rsp_removed_value,
   output logic                                 rsp_found,
   output logic [bol_pkg::ENTRY_W-1:0]          rsp_entry_count
);

   localparam int CNT_W = bol_pkg::CNT_W;
   localparam int ADDR_W = bol_pkg::ADDR_W;
   localparam int CMP_W = bol_pkg::CMP_W;

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  idx_ff, idx_in;
   logic [CNT_W-1:0]                  stop_ff, stop_in;
   logic [bol_pkg::DATA_W-1:0]        value_ff, value_in;
   logic [bol_pkg::DATA_W-1:0]        removed_ff, removed_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [bol_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [bol_pkg::DATA_W-1:0]        rsp_removed_ff, rsp_removed_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [bol_pkg::ENTRY_W-1:0]       rsp_count_ff, rsp_count_in;

   logic [CNT_W-1:0]                  last_idx;
   logic [CNT_W-1:0]                  pos_cnt;
   logic [CMP_W-1:0]                  pos_ext, cnt_ext;
   logic [CNT_W-1:0]                  rd_ptr;
   logic [bol_pkg::DATA_W-1:0]        rd_data;
   logic [bol_pkg::DATA_W-1:0]        wr_data;

   assign last_idx = count_ff - CNT_W'(1);
   assign pos_cnt  = CNT_W'(req_position);
   assign pos_ext  = CMP_W'(req_position);
   assign cnt_ext  = CMP_W'(count_ff);

   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CNT_W'(bol_pkg::CAPACITY));
   assign sts.pos_over = (pos_ext > cnt_ext);
   assign sts.pos_ge   = (pos_ext >= cnt_ext);
   assign sts.at_stop  = (idx_ff == stop_ff);
   assign sts.match    = (rd_data == value_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         bol_pkg::RD_IDX_DEC: rd_ptr = idx_ff - CNT_W'(1);
         bol_pkg::RD_IDX_INC: rd_ptr = idx_ff + CNT_W'(1);
         default:             rd_ptr = idx_ff;
      endcase
   end

   assign wr_data = (cmd.wr_sel == bol_pkg::WR_VALUE) ? value_ff : rd_data;

   bol_ram #(
      .WIDTH (bol_pkg::DATA_W),
      .DEPTH (bol_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_ptr[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in     = idx_ff;
      stop_in    = stop_ff;
      value_in   = value_ff;
      removed_in = removed_ff;
      count_in   = count_ff;
      if (cmd.load) begin
         value_in = $unsigned(req_item_value);
         unique case (cmd.idx_sel)
            bol_pkg::SEL_ZERO:  idx_in = '0;
            bol_pkg::SEL_COUNT: idx_in = count_ff;
            bol_pkg::SEL_POS:   idx_in = pos_cnt;
            bol_pkg::SEL_LAST:  idx_in = last_idx;
            default:            idx_in = '0;
         endcase
         unique case (cmd.stop_sel)
            bol_pkg::SEL_ZERO:  stop_in = '0;
            bol_pkg::SEL_COUNT: stop_in = count_ff;
            bol_pkg::SEL_POS:   stop_in = pos_cnt;
            bol_pkg::SEL_LAST:  stop_in = last_idx;
            default:            stop_in = '0;
         endcase
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.idx_dec) begin
         idx_in = idx_ff - CNT_W'(1);
      end
      if (cmd.grab) begin
         removed_in = rd_data;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_strobe_in  = cmd.finish;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      if (cmd.finish) begin
         rsp_status_in  = cmd.status;
         rsp_removed_in = cmd.ret_removed ? removed_ff : '0;
         rsp_found_in   = cmd.found;
         rsp_count_in   = bol_pkg::ENTRY_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      stop_ff        <= stop_in;
      value_ff       <= value_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = $signed(rsp_removed_ff);
   assign rsp_found         = rsp_found_ff;
   assign rsp_entry_count   = rsp_count_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bol_pkg::CAPACITY))
      else $error("entry count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (idx_ff < CNT_W'(bol_pkg::CAPACITY)))
      else $error("write outside entry store");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != bol_pkg::RS_OK) |-> (rsp_removed_value == '0))
      else $error("removed value on a refused command");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |-> (rsp_status == bol_pkg::RS_OK))
      else $error("found flag with error status");

   assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.full)
      else $error("count advanced on a full list");

endmodule
